// ----- hdl/wds_pkg.sv -----
// ----------------------------------------------------------------------------
// wds_pkg
// Shared types and constants of the waypoint dispatch sequencer.
// ----------------------------------------------------------------------------
package wds_pkg;

	localparam int NUM_SLOTS     = 8;
	localparam int MAX_WAYPOINTS = 64;

	localparam logic [1:0] REQ_REPLAN = 2'd0;
	localparam logic [1:0] REQ_LOAD   = 2'd1;
	localparam logic [1:0] REQ_STEP   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] STG_PREPARE = 2'd0;
	localparam logic [1:0] STG_TAKEOFF = 2'd1;
	localparam logic [1:0] STG_FOLLOW  = 2'd2;
	localparam logic [1:0] STG_HOLD    = 2'd3;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_IDLE    = 3'd1;
	localparam logic [2:0] CMD_TAKEOFF = 3'd2;
	localparam logic [2:0] CMD_MOVE    = 3'd3;
	localparam logic [2:0] CMD_HOLD    = 3'd4;

	localparam logic [2:0] CFG_RADIUS   = 3'd0;
	localparam logic [2:0] CFG_START    = 3'd1;
	localparam logic [2:0] CFG_PREPARE  = 3'd2;
	localparam logic [2:0] CFG_HEIGHT   = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT  = 3'd4;
	localparam logic [2:0] CFG_PREFLT   = 3'd5;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture input item, look up slot
		logic replan;
		logic load;
		logic step_init;  // start-time and preflight stages
		logic rd_wp;      // issue store read of next waypoint
		logic square;     // register squared terms
		logic sum;        // register distance sum / compare
		logic advance;    // next waypoint++
		logic finish;     // write back, build result
	} wds_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_step;
		logic step_ok;    // slot valid, unfinished, has plan
		logic pre_done;   // preflight stage answered
		logic in_plan;    // next waypoint inside plan
		logic reached;    // distance within radius
	} wds_sts_t;

endpackage

// ----- hdl/wds_ctrl.sv -----
// ----------------------------------------------------------------------------
// wds_ctrl
// Sequencer for one item: lookup, preflight, waypoint skip loop, result.
// ----------------------------------------------------------------------------
module wds_ctrl
	import wds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  wds_sts_t sts,
	output wds_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_DST  = 3'd3;
	localparam logic [2:0] S_SUM  = 3'd4;
	localparam logic [2:0] S_CHK  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_full_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_full_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (!sts.is_step) begin
					cmd.replan = 1'b1;
					cmd.load = 1'b1;
					state_d = S_IDLE;
				end else if (!sts.step_ok) begin
					state_d = S_FIN;
				end else begin
					cmd.step_init = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (sts.pre_done || !sts.in_plan) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_wp = 1'b1;
					state_d = S_DST;
				end
			end
			S_DST: begin
				cmd.square = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.reached) begin
					cmd.advance = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// wait for room in the result register
				if (!out_full_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)     out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/wds_datapath.sv -----
// ----------------------------------------------------------------------------
// wds_datapath
// Slot state, waypoint store, distance unit and result register.
// ----------------------------------------------------------------------------
module wds_datapath
	import wds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  wds_cmd_t     cmd,
	output wds_sts_t     sts,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic [103:0] in_data,
	input  logic         in_last,
	input  logic [1:0]   in_user,
	output logic [95:0]  out_data,
	output logic [2:0]   out_user
);

	// configuration
	logic [15:0] radius_q, prep_q, height_q, tmo_q;
	logic [5:0]  startw_q;
	logic        preflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd500;
			startw_q <= '0;
			prep_q   <= 16'd2000;
			height_q <= 16'd1000;
			tmo_q    <= 16'd10000;
			preflt_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS:  radius_q <= (cfg_data < 16'd100)  ? 16'd100  : cfg_data;
				CFG_START:   startw_q <= cfg_data[5:0];
				CFG_PREPARE: prep_q   <= (cfg_data < 16'd500)  ? 16'd500  : cfg_data;
				CFG_HEIGHT:  height_q <= (cfg_data < 16'd200)  ? 16'd200  : cfg_data;
				CFG_TIMEOUT: tmo_q    <= (cfg_data < 16'd1000) ? 16'd1000 : cfg_data;
				CFG_PREFLT:  preflt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// latched item
	logic [1:0]  req_q;
	logic [2:0]  slot_q;
	logic [5:0]  idx_q;
	logic signed [19:0] x_q, y_q, z_q;
	logic        last_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= in_user;
			slot_q <= in_data[2:0];
			idx_q  <= in_data[8:3];
			x_q    <= in_data[28:9];
			y_q    <= in_data[48:29];
			z_q    <= in_data[68:49];
			last_q <= in_last;
			now_q  <= in_data[100:69];
		end
	end

	// slot state; every 3-bit slot and 6-bit index is in range
	logic [6:0]  plen_q  [NUM_SLOTS];
	logic [5:0]  nwp_q   [NUM_SLOTS];
	logic [1:0]  stg_q   [NUM_SLOTS];
	logic [31:0] t0_q    [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] val_q, old_q, fin_q, known_q;

	logic [2:0] s;
	assign s = slot_q;

	// working copies during a step
	logic [6:0]    nwp_w;
	logic [1:0]    stg_w;
	logic [31:0]   t0_w;
	logic          pre_done_q;
	logic [2:0]    kind_pre_q;

	// preflight decision, combinational from slot state
	logic [31:0] t0_eff, el1, el2;
	logic [1:0]  stg_n;
	logic [31:0] t0_n;
	logic        pd_n;
	logic [2:0]  kp_n;
	always_comb begin
		t0_eff = known_q[s] ? t0_q[s] : now_q;
		stg_n = stg_q[s];
		t0_n = t0_eff;
		pd_n = 1'b0;
		kp_n = CMD_NONE;
		el1 = now_q - t0_eff;
		if (preflt_q && stg_n == STG_PREPARE) begin
			if (el1 < {16'd0, prep_q}) begin
				pd_n = 1'b1; kp_n = CMD_IDLE;
			end else begin
				stg_n = STG_TAKEOFF; t0_n = now_q;
			end
		end
		el2 = now_q - t0_n;
		if (!pd_n && preflt_q && stg_n == STG_TAKEOFF) begin
			if (z_q < $signed({5'd0, height_q}) && el2 < {16'd0, tmo_q}) begin
				pd_n = 1'b1; kp_n = CMD_TAKEOFF;
			end else begin
				stg_n = STG_FOLLOW; t0_n = now_q;
			end
		end
	end

	// waypoint store, {z, y, x} per slot and index
	logic [59:0] mem [NUM_SLOTS*MAX_WAYPOINTS];
	logic [59:0] wp_rd;
	logic [8:0]  wr_addr, rd_addr;
	assign wr_addr = {s, idx_q};
	assign rd_addr = {s, nwp_w[5:0]};

	always_ff @(posedge clk) begin
		if (cmd.load && req_q == REQ_LOAD)
			mem[wr_addr] <= {z_q, y_q, x_q};
		if (cmd.rd_wp) wp_rd <= mem[rd_addr];
	end

	// distance unit
	logic signed [20:0] dx, dy, dz;
	logic signed [41:0] px, py, pz;
	logic [40:0] sqx_q, sqy_q, sqz_q;
	logic [42:0] d2;
	logic [31:0] r2;
	logic        reached_q;
	assign dx = $signed({x_q[19], x_q}) - $signed({wp_rd[19], wp_rd[19:0]});
	assign dy = $signed({y_q[19], y_q}) - $signed({wp_rd[39], wp_rd[39:20]});
	assign dz = $signed({z_q[19], z_q}) - $signed({wp_rd[59], wp_rd[59:40]});
	assign px = dx * dx;
	assign py = dy * dy;
	assign pz = dz * dz;
	assign d2 = {2'd0, sqx_q} + {2'd0, sqy_q} + {2'd0, sqz_q};
	assign r2 = {16'd0, radius_q} * {16'd0, radius_q};

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= px[40:0];
			sqy_q <= py[40:0];
			sqz_q <= pz[40:0];
		end
		if (cmd.sum) reached_q <= (d2 <= {11'd0, r2});
	end

	assign sts.is_step  = (req_q == REQ_STEP);
	assign sts.step_ok  = val_q[s] && !fin_q[s] && (plen_q[s] != '0);
	assign sts.pre_done = pre_done_q;
	assign sts.in_plan  = (nwp_w < plen_q[s]);
	assign sts.reached  = reached_q;

	// result of the step
	logic [31:0] cnt_q;
	logic [2:0]  kind;
	logic        fin_n, done_n;
	logic [59:0] tgt;
	logic [31:0] num;
	always_comb begin
		kind = CMD_NONE;
		fin_n = 1'b0;
		tgt = '0;
		num = '0;
		if (sts.step_ok) begin
			num = cnt_q + 32'd1;
			if (pre_done_q) kind = kind_pre_q;
			else if (!sts.in_plan) begin
				kind = CMD_HOLD; fin_n = 1'b1; tgt = {z_q, y_q, x_q};
			end else begin
				kind = CMD_MOVE; tgt = wp_rd;
			end
		end
	end
	assign done_n = fin_q[s] | fin_n;

	logic [5:0] first_n;
	assign first_n = (startw_q < idx_q) ? startw_q : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0; old_q <= '0; fin_q <= '0; known_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				plen_q[i] <= '0; nwp_q[i] <= '0; stg_q[i] <= STG_PREPARE; t0_q[i] <= '0;
			end
			nwp_w <= '0; stg_w <= STG_PREPARE; t0_w <= '0;
			pre_done_q <= 1'b0; kind_pre_q <= CMD_NONE;
			out_data <= '0; out_user <= CMD_NONE;
		end else begin
			if (cmd.replan && req_q == REQ_REPLAN) begin
				old_q <= val_q; val_q <= '0;
			end
			if (cmd.load && req_q == REQ_LOAD && last_q) begin
				plen_q[s] <= {1'b0, idx_q} + 7'd1;
				nwp_q[s]  <= first_n;
				fin_q[s] <= 1'b0;
				val_q[s] <= 1'b1;
				if (old_q[s] || val_q[s]) begin
					if (stg_q[s] == STG_FOLLOW || stg_q[s] == STG_HOLD) stg_q[s] <= STG_FOLLOW;
				end else begin
					stg_q[s] <= preflt_q ? STG_PREPARE : STG_FOLLOW;
					known_q[s] <= 1'b0;
				end
			end
			if (cmd.step_init) begin
				nwp_w <= {1'b0, nwp_q[s]};
				stg_w <= stg_n;
				t0_w  <= t0_n;
				pre_done_q <= pd_n;
				kind_pre_q <= kp_n;
			end
			if (cmd.advance) nwp_w <= nwp_w + 7'd1;
			if (cmd.finish) begin
				if (sts.step_ok) begin
					cnt_q <= num;
					known_q[s] <= 1'b1;
					t0_q[s] <= t0_w;
					stg_q[s] <= fin_n ? STG_HOLD : stg_w;
					nwp_q[s] <= nwp_w[5:0];
					fin_q[s] <= fin_n;
				end
				out_data <= {2'b00, val_q[s] && !done_n, val_q[s] && done_n, num, tgt};
				out_user <= kind;
			end
		end
	end

endmodule

// ----- hdl/waypoint_dispatch_sequencer.sv -----
// ----------------------------------------------------------------------------
// waypoint_dispatch_sequencer
// Per-vehicle waypoint dispatcher: plan load, preflight stages, path follow.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | contents
//  s_axis  | in        | tvalid/tready      | request item, tuser req_type, tlast is_last
//  m_axis  | out       | tvalid/tready      | command item (step only), tuser cmd_kind
//  cfg     | in        | cfg_we             | register write
//
// Replan and load items return from lookup to idle. A step answered in prepare
// or takeoff passes the read state to the result; a following step reads,
// squares and sums the distance of each waypoint examined and ends when one is
// not reached or the path ends. An invalid step goes to the result. Reset is
// asynchronous and needs no clearing pass. One item is in work at a time; a
// result waits in the output register and only the next result stalls on it.
module waypoint_dispatch_sequencer
	import wds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // uav_slot, wp_index, x, y, z, now_ms
	input  logic         s_axis_tlast,  // is_last
	input  logic [1:0]   s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // x, y, z, command_number, path_done, path_active
	output logic [2:0]   m_axis_tuser,  // cmd_kind
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	wds_cmd_t cmd;
	wds_sts_t sts;

	wds_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts, .cmd
	);

	wds_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
		.in_data(s_axis_tdata), .in_last(s_axis_tlast), .in_user(s_axis_tuser),
		.out_data(m_axis_tdata), .out_user(m_axis_tuser)
	);

endmodule
